/* rtl/uchrb_pkg.sv */
package uchrb_pkg;

  localparam int CHANNELS = 3;
  localparam int RX_DEPTH = 64;
  localparam int TX_DEPTH = 64;

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int RX_PW = $clog2(RX_DEPTH);
  localparam int TX_PW = $clog2(TX_DEPTH);
  localparam int RX_AW = (CHANNELS * RX_DEPTH > 1) ? $clog2(CHANNELS * RX_DEPTH) : 1;
  localparam int TX_AW = (CHANNELS * TX_DEPTH > 1) ? $clog2(CHANNELS * TX_DEPTH) : 1;

  typedef enum logic [2:0] {
    KIND_LINE_RX  = 3'd0,
    KIND_HOST_POP = 3'd1,
    KIND_HOST_PSH = 3'd2,
    KIND_TX_SLOT  = 3'd3,
    KIND_CLEAR    = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_EMPTY = 3'd1,
    ST_FULL  = 3'd2,
    ST_IDLE  = 3'd3,
    ST_BADCH = 3'd4
  } status_t;

  typedef struct packed {
    logic             en;
    logic             we;
    logic [RX_AW-1:0] addr;
    logic [7:0]       wdata;
  } rx_req_t;

  typedef struct packed {
    logic             en;
    logic             we;
    logic [TX_AW-1:0] addr;
    logic [7:0]       wdata;
  } tx_req_t;

  typedef struct packed {
    status_t status;
    logic    rd_sel;
    logic    line_valid;
    logic    sending;
  } res_t;

  function automatic logic [RX_PW-1:0] rx_adv(input logic [RX_PW-1:0] p);
    return (int'(p) == RX_DEPTH - 1) ? '0 : RX_PW'(int'(p) + 1);
  endfunction

  function automatic logic [TX_PW-1:0] tx_adv(input logic [TX_PW-1:0] p);
    return (int'(p) == TX_DEPTH - 1) ? '0 : TX_PW'(int'(p) + 1);
  endfunction

endpackage

/* rtl/uchrb_byte_ram.sv */
module uchrb_byte_ram #(
  parameter int DEPTH = 192,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          en,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

/* rtl/uchrb_ctrl.sv */
module uchrb_ctrl
  import uchrb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [2:0] in_kind,
  input  logic [2:0] in_channel,
  input  logic [7:0] in_data,
  input  logic       in_end,
  output logic       out_valid,
  input  logic       out_tready,
  output res_t       res,
  output rx_req_t    rx_req,
  output tx_req_t    tx_req
);

  logic [RX_PW-1:0] rx_head_r [CHANNELS];
  logic [RX_PW-1:0] rx_head_nxt [CHANNELS];
  logic [RX_PW-1:0] rx_tail_r [CHANNELS];
  logic [RX_PW-1:0] rx_tail_nxt [CHANNELS];
  logic [TX_PW-1:0] tx_head_r [CHANNELS];
  logic [TX_PW-1:0] tx_head_nxt [CHANNELS];
  logic [TX_PW-1:0] tx_tail_r [CHANNELS];
  logic [TX_PW-1:0] tx_tail_nxt [CHANNELS];
  logic [CHANNELS-1:0] tx_on_r, tx_on_nxt;

  logic out_valid_r, out_valid_nxt;
  res_t res_r, res_nxt;

  logic             accept;
  logic             bad;
  logic [CH_W-1:0]  chi;
  logic [RX_PW-1:0] rx_nx;
  logic [TX_PW-1:0] tx_nx;
  logic [TX_PW-1:0] tx_new_head;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign bad       = {1'b0, in_channel} >= 4'(CHANNELS);
  assign chi       = in_channel[CH_W-1:0];
  assign out_valid = out_valid_r;
  assign res       = res_r;

  always_comb begin
    rx_head_nxt = rx_head_r;
    rx_tail_nxt = rx_tail_r;
    tx_head_nxt = tx_head_r;
    tx_tail_nxt = tx_tail_r;
    tx_on_nxt   = tx_on_r;
    rx_req      = '0;
    tx_req      = '0;
    res_nxt     = '{status: ST_OK, rd_sel: 1'b0, line_valid: 1'b0, sending: 1'b0};
    rx_nx       = rx_adv(rx_head_r[chi]);
    tx_nx       = tx_adv(tx_head_r[chi]);
    tx_new_head = tx_head_r[chi];
    rx_req.wdata = in_data;
    tx_req.wdata = in_data;

    if (bad) begin
      res_nxt.status = ST_BADCH;
    end else begin
      case (kind_t'(in_kind))
        KIND_LINE_RX: begin
          if (rx_nx == rx_tail_r[chi]) begin
            res_nxt.status = ST_FULL;
          end else begin
            rx_req.en   = accept;
            rx_req.we   = 1'b1;
            rx_req.addr = RX_AW'(int'(chi) * RX_DEPTH + int'(rx_head_r[chi]));
            rx_head_nxt[chi] = rx_nx;
          end
        end
        KIND_HOST_POP: begin
          if (rx_head_r[chi] == rx_tail_r[chi]) begin
            res_nxt.status = ST_EMPTY;
          end else begin
            rx_req.en   = accept;
            rx_req.addr = RX_AW'(int'(chi) * RX_DEPTH + int'(rx_tail_r[chi]));
            res_nxt.rd_sel = 1'b1;
            rx_tail_nxt[chi] = rx_adv(rx_tail_r[chi]);
          end
        end
        KIND_HOST_PSH: begin
          if (tx_nx == tx_tail_r[chi]) begin
            res_nxt.status = ST_FULL;
          end else begin
            tx_req.en   = accept;
            tx_req.we   = 1'b1;
            tx_req.addr = TX_AW'(int'(chi) * TX_DEPTH + int'(tx_head_r[chi]));
            tx_new_head = tx_nx;
            tx_head_nxt[chi] = tx_nx;
          end
          if (in_end && tx_new_head != tx_tail_r[chi]) begin
            tx_on_nxt[chi] = 1'b1;
          end
        end
        KIND_TX_SLOT: begin
          if (!tx_on_r[chi] || tx_head_r[chi] == tx_tail_r[chi]) begin
            tx_on_nxt[chi] = 1'b0;
            res_nxt.status = ST_IDLE;
          end else begin
            tx_req.en   = accept;
            tx_req.addr = TX_AW'(int'(chi) * TX_DEPTH + int'(tx_tail_r[chi]));
            res_nxt.line_valid = 1'b1;
            tx_tail_nxt[chi] = tx_adv(tx_tail_r[chi]);
            if (tx_head_r[chi] == tx_adv(tx_tail_r[chi])) begin
              tx_on_nxt[chi] = 1'b0;
            end
          end
        end
        KIND_CLEAR: begin
          rx_head_nxt[chi] = '0;
          rx_tail_nxt[chi] = '0;
          tx_head_nxt[chi] = '0;
          tx_tail_nxt[chi] = '0;
          tx_on_nxt[chi]   = 1'b0;
        end
        default: begin
        end
      endcase
      res_nxt.sending = tx_on_nxt[chi];
    end
  end

  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        rx_head_r[i] <= '0;
        rx_tail_r[i] <= '0;
        tx_head_r[i] <= '0;
        tx_tail_r[i] <= '0;
      end
      tx_on_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        rx_head_r <= rx_head_nxt;
        rx_tail_r <= rx_tail_nxt;
        tx_head_r <= tx_head_nxt;
        tx_tail_r <= tx_tail_nxt;
        tx_on_r   <= tx_on_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

endmodule

/* rtl/uart_channel_ring_buffers.sv */
// channel  dir  tdata (low bit up)                             tuser    tlast
// in_      in   channel[2:0] data[10:3] pad[15:11]              kind     block_end
// out_     out  read_data[7:0] line_data[15:8] line_valid[16]   status   -
//               sending[17] pad[23:18]
// One beat per cycle: pointers and tx flags sit in flops, ring bytes in two
// single-port RAMs (one access per beat, read data ready the next cycle).
// Result is registered and shown in the cycle after the input beat; a new input beat is
// taken while the result is being taken. Stalled output holds input off.
// Reset (rst_n low, sync) empties all rings; ring RAMs need no clearing.
module uart_channel_ring_buffers
  import uchrb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // channel, data
  input  logic [2:0]  in_tuser,   // kind
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // read_data, line_data, line_valid, sending
  output logic [2:0]  out_tuser   // status
);

  res_t    res;
  rx_req_t rx_req;
  tx_req_t tx_req;
  logic [7:0] rx_rdata;
  logic [7:0] tx_rdata;

  uchrb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_kind    (in_tuser),
    .in_channel (in_tdata[2:0]),
    .in_data    (in_tdata[10:3]),
    .in_end     (in_tlast),
    .out_valid  (out_tvalid),
    .out_tready (out_tready),
    .res        (res),
    .rx_req     (rx_req),
    .tx_req     (tx_req)
  );

  uchrb_byte_ram #(
    .DEPTH (CHANNELS * RX_DEPTH),
    .AW    (RX_AW)
  ) u_rx_ram (
    .clk   (clk),
    .en    (rx_req.en),
    .we    (rx_req.we),
    .addr  (rx_req.addr),
    .wdata (rx_req.wdata),
    .rdata (rx_rdata)
  );

  uchrb_byte_ram #(
    .DEPTH (CHANNELS * TX_DEPTH),
    .AW    (TX_AW)
  ) u_tx_ram (
    .clk   (clk),
    .en    (tx_req.en),
    .we    (tx_req.we),
    .addr  (tx_req.addr),
    .wdata (tx_req.wdata),
    .rdata (tx_rdata)
  );

  assign out_tuser = res.status;
  assign out_tdata = {6'd0, res.sending, res.line_valid,
                      res.line_valid ? tx_rdata : 8'd0,
                      res.rd_sel ? rx_rdata : 8'd0};

endmodule
